@@ rtl/point_in_polygon_test_defines.svh @@
// Assertion helpers for the point-in-polygon block.
// They expect i_clk and i_rst_n in the scope where they are used.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Same-cycle implication.
`define PIP_ASSERT_NOW(lbl, cond, consq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (consq)) \
        else $error(msg);

// Next-cycle implication.
`define PIP_ASSERT_NEXT(lbl, cond, consq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

@@ rtl/pip_pkg.sv @@
package pip_pkg;

    localparam int CoordW     = 16;
    localparam int DiffW      = CoordW + 1;
    localparam int ProdW      = 2 * DiffW;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int InDataW    = ((2 * CoordW + 7) / 8) * 8;
    localparam int OutDataW   = ((2 + 7) / 8) * 8;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef enum logic [0:0] {
        CFG_QUERY_X = 1'b0,
        CFG_QUERY_Y = 1'b1
    } t_cfg_addr;

    // One request: edge prev->cur (unless start), closing edge cur->first (if last)
    typedef struct packed {
        t_point prev;
        t_point cur;
        t_point first;
        logic   start;
        logic   last;
    } t_edge_req;

    typedef struct packed {
        logic signed [ProdW-1:0] p_cross_a;
        logic signed [ProdW-1:0] p_cross_b;
        logic signed [ProdW-1:0] p_lhs;
        logic signed [ProdW-1:0] p_rhs;
        logic                    in_box;
        logic                    in_band;
        logic                    dy_pos;
        logic                    valid;
    } t_edge_part;

    typedef struct packed {
        logic on_edge;
        logic crossing;
    } t_edge_eval;

    typedef struct packed {
        logic s1_valid;
        logic s1_last;
    } t_back_stat;

    // First half of an edge test: differences, products, coordinate compares.
    function automatic t_edge_part edge_prep(t_point a, t_point b, t_point q, logic valid);
        logic signed [DiffW-1:0] dxa;
        logic signed [DiffW-1:0] dya;
        logic signed [DiffW-1:0] dxb;
        logic signed [DiffW-1:0] dyb;
        logic signed [DiffW-1:0] ex;
        logic signed [DiffW-1:0] ey;
        t_edge_part              r;
        dxa = DiffW'(a.x) - DiffW'(q.x);
        dya = DiffW'(a.y) - DiffW'(q.y);
        dxb = DiffW'(b.x) - DiffW'(q.x);
        dyb = DiffW'(b.y) - DiffW'(q.y);
        ex  = DiffW'(b.x) - DiffW'(a.x);
        ey  = DiffW'(b.y) - DiffW'(a.y);
        r.p_cross_a = ProdW'(dxa) * ProdW'(dyb);
        r.p_cross_b = ProdW'(dya) * ProdW'(dxb);
        r.p_lhs     = (-ProdW'(dya)) * ProdW'(ex);
        r.p_rhs     = (-ProdW'(dxa)) * ProdW'(ey);
        r.in_box    = (a.x <= q.x || b.x <= q.x) && (a.x >= q.x || b.x >= q.x)
                   && (a.y <= q.y || b.y <= q.y) && (a.y >= q.y || b.y >= q.y);
        r.in_band   = (a.y <= q.y || b.y <= q.y) && (a.y > q.y || b.y > q.y);
        r.dy_pos    = b.y > a.y;
        r.valid     = valid;
        return r;
    endfunction

    // Second half: zero cross product and the signed intersection compare.
    function automatic t_edge_eval edge_finish(t_edge_part p);
        t_edge_eval r;
        r.on_edge  = p.valid && p.in_box && (p.p_cross_a == p.p_cross_b);
        r.crossing = p.valid && p.in_band
                  && (p.dy_pos ? (p.p_lhs >= p.p_rhs) : (p.p_lhs <= p.p_rhs));
        return r;
    endfunction

endpackage

@@ rtl/point_in_polygon_test.sv @@
// Point-in-polygon test, ray casting with even-odd rule, one vertex per request.
// Throughput: one vertex per cycle, held off while the queue is full or a finished result
// waits on a blocked output; both edges a vertex closes are tested in parallel lanes of a
// two-step datapath (products, then compare and accumulate).
// Reset: i_rst_n synchronous, active low; clears query to 0, queue, pipeline, polygon state.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // vertex stream in
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [pip_pkg::InDataW-1:0]  i_s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    input  logic                         i_s_tlast,   // last_vertex
    // result stream out
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [pip_pkg::OutDataW-1:0] o_m_tdata,   // [0] inside_res, [1] on_boundary, rest 0
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_addr,  // 0 query_x, 1 query_y
    input  logic [pip_pkg::CoordW-1:0]   i_cfg_data
);
    import pip_pkg::*;

    // query point registers
    t_point     r_query;

    t_point     vertex;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    t_edge_req  front_req;
    t_edge_req  q_req;
    logic       res_inside;
    logic       res_on;
    t_back_stat back_stat;
    logic       s1_last_v;
    logic       out_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_QUERY_X: r_query.x <= i_cfg_data;
                CFG_QUERY_Y: r_query.y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign vertex.x = i_s_tdata[CoordW-1:0];
    assign vertex.y = i_s_tdata[2*CoordW-1:CoordW];

    // front: keeps first and previous vertex, turns each vertex into an edge request
    pip_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_vertex (vertex),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_req    (front_req)
    );

    // short queue decouples vertex intake from the result side
    pip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    // back: edge arithmetic, crossing parity, boundary hit, result register
    pip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_query       (r_query),
        .i_q_valid     (q_valid),
        .i_req         (q_req),
        .o_pop         (q_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_inside      (res_inside),
        .o_on_boundary (res_on),
        .o_stat        (back_stat)
    );

    assign o_m_tdata = {{(OutDataW-2){1'b0}}, res_on, res_inside};

    // last vertex sitting in stage 1, result side blocked
    assign s1_last_v = back_stat.s1_valid && back_stat.s1_last;
    assign out_stall = o_m_tvalid && !i_m_tready;

    // on the boundary always counts as inside
    `PIP_ASSERT_NOW(a_on_implies_inside, o_m_tvalid && res_on, res_inside, "boundary without inside")
    // a new result only follows a last vertex leaving stage 1
    `PIP_ASSERT_NOW(a_result_from_last, $rose(o_m_tvalid), $past(s1_last_v), "no last vertex")
    // a finished polygon waits in stage 1 while the output is blocked
    `PIP_ASSERT_NEXT(a_last_held, s1_last_v && out_stall, s1_last_v, "pending result dropped")

endmodule

@@ rtl/pip_front.sv @@
module pip_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pip_pkg::t_point    i_vertex,
    input  logic               i_last,
    input  logic               i_q_full,
    output logic               o_push,
    output pip_pkg::t_edge_req o_req
);
    import pip_pkg::*;

    t_point r_first;
    t_point r_prev;
    logic   r_await;
    logic   n_await;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_req.prev  = r_prev;
        o_req.cur   = i_vertex;
        o_req.first = r_await ? i_vertex : r_first;
        o_req.start = r_await;
        o_req.last  = i_last;
    end

    always_comb begin
        n_await = r_await;
        if (o_push) begin
            n_await = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
        end else begin
            r_await <= n_await;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev <= i_vertex;
            if (r_await) begin
                r_first <= i_vertex;
            end
        end
    end

endmodule

@@ rtl/pip_queue.sv @@
module pip_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pip_pkg::t_edge_req i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output pip_pkg::t_edge_req o_data
);
    import pip_pkg::*;

    t_edge_req        r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QPtrW:0]   r_cnt;
    logic [QPtrW:0]   n_cnt;

    assign o_full  = (r_cnt == (QPtrW+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/pip_back.sv @@
module pip_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pip_pkg::t_point     i_query,
    input  logic                i_q_valid,
    input  pip_pkg::t_edge_req  i_req,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_inside,
    output logic                o_on_boundary,
    output pip_pkg::t_back_stat o_stat
);
    import pip_pkg::*;

    // stage 1: products for both edges of one request
    logic       r_s1_v;
    t_edge_part r_s1_e1;
    t_edge_part r_s1_e2;
    logic       r_s1_start;
    logic       r_s1_last;
    // running polygon state
    logic       r_parity;
    logic       r_hit;
    // result register
    logic       r_out_v;
    logic       r_out_inside;
    logic       r_out_on;

    logic       n_s1_v;
    logic       n_out_v;
    logic       out_free;
    logic       s1_go;
    t_edge_eval ev1;
    t_edge_eval ev2;
    logic       acc_par;
    logic       acc_hit;

    assign out_free = !r_out_v || i_ready;
    assign s1_go    = r_s1_v && (!r_s1_last || out_free);
    assign o_pop    = i_q_valid && (!r_s1_v || s1_go);

    assign ev1     = edge_finish(r_s1_e1);
    assign ev2     = edge_finish(r_s1_e2);
    assign acc_par = (r_parity && !r_s1_start) ^ ev1.crossing ^ ev2.crossing;
    assign acc_hit = (r_hit && !r_s1_start) || ev1.on_edge || ev2.on_edge;

    always_comb begin
        n_s1_v = r_s1_v;
        if (o_pop) begin
            n_s1_v = 1'b1;
        end else if (s1_go) begin
            n_s1_v = 1'b0;
        end
        n_out_v = r_out_v && !i_ready;
        if (s1_go && r_s1_last) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_parity <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
            if (s1_go) begin
                r_parity <= acc_par && !r_s1_last;
                r_hit    <= acc_hit && !r_s1_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_e1    <= edge_prep(i_req.prev, i_req.cur, i_query, !i_req.start);
            r_s1_e2    <= edge_prep(i_req.cur, i_req.first, i_query, i_req.last);
            r_s1_start <= i_req.start;
            r_s1_last  <= i_req.last;
        end
        if (s1_go && r_s1_last) begin
            r_out_inside <= acc_par || acc_hit;
            r_out_on     <= acc_hit;
        end
    end

    assign o_valid         = r_out_v;
    assign o_inside        = r_out_inside;
    assign o_on_boundary   = r_out_on;
    assign o_stat.s1_valid = r_s1_v;
    assign o_stat.s1_last  = r_s1_last;

endmodule
